/* rtl/qrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, side-band types and rounding helper for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   localparam int W        = WORD_BITS;
   localparam int DW       = 2 * W + 2;          // discriminant width
   localparam int SQ_STEPS = W + 1;              // root bits
   localparam int RES_W    = W + 1;
   localparam int QM_W     = W + 2;
   localparam int DEN_W    = W + 2;
   localparam int NUM_W    = W + 2 + FRAC_BITS;  // dividend width, one step per bit

   typedef struct packed {
      logic         valid;
      logic         an;
      logic         bn;
      logic         cn;
      logic [W-1:0] am;
      logic [W-1:0] bm;
      logic [W-1:0] cm;
   } coef_type;

   typedef struct packed {
      logic         valid;
      logic         has;
      logic         dbl;
      logic         an;
      logic         bn;
      logic         cn;
      logic [W-1:0] am;
      logic [W-1:0] bm;
      logic [W-1:0] cm;
   } sq_side_type;

   typedef struct packed {
      logic valid;
      logic has;
      logic dbl;
      logic neg1;
      logic neg2;
      logic dz1;
      logic dz2;
   } dv_side_type;

   typedef struct packed {
      logic [W-1:0] value;
      logic         sat;
   } root_type;

   function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
      magnitude = v[W-1] ? (~v + W'(1)) : v;
   endfunction

   // nearest, ties away from zero, then clamp to the word
   function automatic root_type round_clamp(input logic             neg,
                                            input logic             dz,
                                            input logic [NUM_W-1:0] quo,
                                            input logic [DEN_W-1:0] rem,
                                            input logic [DEN_W-1:0] den);
      logic [NUM_W:0] q1;
      logic [NUM_W:0] lim;
      logic [W-1:0]   mag;
      logic           sat;
      root_type       res;
      q1  = {1'b0, quo} + (({rem, 1'b0} >= {1'b0, den}) ? (NUM_W+1)'(1) : (NUM_W+1)'(0));
      lim = neg ? ((NUM_W+1)'(1) << (W-1)) : (((NUM_W+1)'(1) << (W-1)) - (NUM_W+1)'(1));
      sat = 1'b0;
      if (dz || (q1 > lim)) begin
         sat = 1'b1;
         mag = lim[W-1:0];
      end else begin
         mag = q1[W-1:0];
      end
      res.value = neg ? (~mag + W'(1)) : mag;
      res.sat   = sat;
      return res;
   endfunction

endpackage

/* rtl/quadratic_root_solver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Real roots of a*x^2+b*x+c in signed fixed point, fully pipelined.
// Pipeline: input, multiply, discriminant, one stage per root bit, divider
//   set-up, one stage per quotient bit, round, output.
// Throughput: one request per cycle; the whole pipe holds while a result waits.
// Reset: synchronous, active high, clears all valid bits.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core import qrs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [W-1:0] req_coef_a,
   input  logic [W-1:0] req_coef_b,
   input  logic [W-1:0] req_coef_c,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_has_roots,
   output logic [W-1:0] rsp_root_low,
   output logic [W-1:0] rsp_root_high,
   output logic         rsp_saturated
);

   logic adv;

   coef_type     a_ff;
   coef_type     b_ff;
   logic [2*W-1:0] p_ff;
   logic [2*W-1:0] ac_ff;

   sq_side_type  sq_side_ff [0:SQ_STEPS];
   logic [DW-1:0] sq_num_ff [0:SQ_STEPS];
   logic [DW-1:0] sq_res_ff [0:SQ_STEPS];

   dv_side_type      dv_side_ff [0:NUM_W];
   logic [NUM_W-1:0] dv1_num_ff [0:NUM_W];
   logic [NUM_W-1:0] dv1_quo_ff [0:NUM_W];
   logic [DEN_W-1:0] dv1_rem_ff [0:NUM_W];
   logic [DEN_W-1:0] dv1_den_ff [0:NUM_W];
   logic [NUM_W-1:0] dv2_num_ff [0:NUM_W];
   logic [NUM_W-1:0] dv2_quo_ff [0:NUM_W];
   logic [DEN_W-1:0] dv2_rem_ff [0:NUM_W];
   logic [DEN_W-1:0] dv2_den_ff [0:NUM_W];

   dv_side_type r_side_ff;
   root_type    r1_ff;
   root_type    r2_ff;

   logic         rsp_valid_ff;
   logic         rsp_has_ff;
   logic [W-1:0] rsp_low_ff;
   logic [W-1:0] rsp_high_ff;
   logic         rsp_sat_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // input: signs and magnitudes
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
      end else if (adv) begin
         a_ff.valid <= req_valid;
         a_ff.an    <= req_coef_a[W-1];
         a_ff.bn    <= req_coef_b[W-1];
         a_ff.cn    <= req_coef_c[W-1];
         a_ff.am    <= magnitude(req_coef_a);
         a_ff.bm    <= magnitude(req_coef_b);
         a_ff.cm    <= magnitude(req_coef_c);
      end
   end

   // products
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0;
      end else if (adv) begin
         b_ff <= a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff  <= a_ff.bm * a_ff.bm;
         ac_ff <= a_ff.am * a_ff.cm;
      end
   end

   // discriminant
   logic [DW-1:0] p_ext_in;
   logic [DW-1:0] rr_in;
   logic          acneg_in;
   logic          has_in;
   logic [DW-1:0] d_in;

   always_comb begin
      p_ext_in = {2'b00, p_ff};
      rr_in    = {ac_ff, 2'b00};
      acneg_in = b_ff.an ^ b_ff.cn;
      has_in   = acneg_in || (p_ext_in >= rr_in);
      if (!has_in) begin
         d_in = '0;
      end else if (acneg_in) begin
         d_in = p_ext_in + rr_in;
      end else begin
         d_in = p_ext_in - rr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_side_ff[0] <= '0;
      end else if (adv) begin
         sq_side_ff[0].valid <= b_ff.valid;
         sq_side_ff[0].has   <= has_in;
         sq_side_ff[0].dbl   <= (d_in == '0);
         sq_side_ff[0].an    <= b_ff.an;
         sq_side_ff[0].bn    <= b_ff.bn;
         sq_side_ff[0].cn    <= b_ff.cn;
         sq_side_ff[0].am    <= b_ff.am;
         sq_side_ff[0].bm    <= b_ff.bm;
         sq_side_ff[0].cm    <= b_ff.cm;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_num_ff[0] <= d_in;
         sq_res_ff[0] <= '0;
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam logic [DW-1:0] Bit = {{(DW-1){1'b0}}, 1'b1} << (DW - 2 - 2 * k);
      logic [DW-1:0] t;
      logic          ge;
      assign t  = sq_res_ff[k] + Bit;
      assign ge = sq_num_ff[k] >= t;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_side_ff[k+1] <= '0;
         end else if (adv) begin
            sq_side_ff[k+1] <= sq_side_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_num_ff[k+1] <= ge ? (sq_num_ff[k] - t) : sq_num_ff[k];
            sq_res_ff[k+1] <= ge ? ((sq_res_ff[k] >> 1) + Bit) : (sq_res_ff[k] >> 1);
         end
      end
   end

   // q magnitude and divider set-up
   sq_side_type     qs;
   logic [QM_W-1:0] qm_in;
   logic            qneg_in;

   assign qs      = sq_side_ff[SQ_STEPS];
   assign qm_in   = QM_W'(qs.bm) + QM_W'(sq_res_ff[SQ_STEPS][RES_W-1:0]);
   assign qneg_in = !qs.bn && (qs.bm != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_side_ff[0] <= '0;
      end else if (adv) begin
         dv_side_ff[0].valid <= qs.valid;
         dv_side_ff[0].has   <= qs.has;
         dv_side_ff[0].dbl   <= qs.dbl;
         dv_side_ff[0].neg1  <= qneg_in ^ qs.an;
         dv_side_ff[0].neg2  <= qs.cn ^ qneg_in;
         dv_side_ff[0].dz1   <= (qs.am == '0);
         dv_side_ff[0].dz2   <= (qm_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv1_num_ff[0] <= NUM_W'(qm_in) << FRAC_BITS;
         dv1_quo_ff[0] <= '0;
         dv1_rem_ff[0] <= '0;
         dv1_den_ff[0] <= {1'b0, qs.am, 1'b0};
         dv2_num_ff[0] <= NUM_W'(qs.cm) << (FRAC_BITS + 1);
         dv2_quo_ff[0] <= '0;
         dv2_rem_ff[0] <= '0;
         dv2_den_ff[0] <= qm_in;
      end
   end

   // two restoring dividers, one quotient bit per stage
   for (genvar k = 0; k < NUM_W; k++) begin : g_div
      logic [DEN_W:0] rs1;
      logic [DEN_W:0] rs2;
      logic [DEN_W:0] df1;
      logic [DEN_W:0] df2;
      logic           ge1;
      logic           ge2;
      assign rs1 = {dv1_rem_ff[k], dv1_num_ff[k][NUM_W-1]};
      assign rs2 = {dv2_rem_ff[k], dv2_num_ff[k][NUM_W-1]};
      assign df1 = rs1 - {1'b0, dv1_den_ff[k]};
      assign df2 = rs2 - {1'b0, dv2_den_ff[k]};
      assign ge1 = rs1 >= {1'b0, dv1_den_ff[k]};
      assign ge2 = rs2 >= {1'b0, dv2_den_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_side_ff[k+1] <= '0;
         end else if (adv) begin
            dv_side_ff[k+1] <= dv_side_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv1_num_ff[k+1] <= dv1_num_ff[k] << 1;
            dv1_quo_ff[k+1] <= {dv1_quo_ff[k][NUM_W-2:0], ge1};
            dv1_rem_ff[k+1] <= ge1 ? df1[DEN_W-1:0] : rs1[DEN_W-1:0];
            dv1_den_ff[k+1] <= dv1_den_ff[k];
            dv2_num_ff[k+1] <= dv2_num_ff[k] << 1;
            dv2_quo_ff[k+1] <= {dv2_quo_ff[k][NUM_W-2:0], ge2};
            dv2_rem_ff[k+1] <= ge2 ? df2[DEN_W-1:0] : rs2[DEN_W-1:0];
            dv2_den_ff[k+1] <= dv2_den_ff[k];
         end
      end
   end

   // round and clamp
   dv_side_type ds;
   assign ds = dv_side_ff[NUM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         r_side_ff <= '0;
      end else if (adv) begin
         r_side_ff <= ds;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_ff <= round_clamp(ds.neg1, ds.dz1, dv1_quo_ff[NUM_W], dv1_rem_ff[NUM_W],
                              dv1_den_ff[NUM_W]);
         r2_ff <= round_clamp(ds.neg2, ds.dz2, dv2_quo_ff[NUM_W], dv2_rem_ff[NUM_W],
                              dv2_den_ff[NUM_W]);
      end
   end

   // ordering and result register
   logic         has_out_in;
   logic [W-1:0] low_in;
   logic [W-1:0] high_in;
   logic         sat_in;

   always_comb begin
      has_out_in = r_side_ff.has;
      if (!r_side_ff.has) begin
         low_in  = '0;
         high_in = '0;
         sat_in  = 1'b0;
      end else if (r_side_ff.dbl) begin
         low_in  = r1_ff.value;
         high_in = r1_ff.value;
         sat_in  = r1_ff.sat;
      end else begin
         sat_in = r1_ff.sat || r2_ff.sat;
         if ($signed(r1_ff.value) > $signed(r2_ff.value)) begin
            low_in  = r2_ff.value;
            high_in = r1_ff.value;
         end else begin
            low_in  = r1_ff.value;
            high_in = r2_ff.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= r_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_has_ff  <= has_out_in;
         rsp_low_ff  <= low_in;
         rsp_high_ff <= high_in;
         rsp_sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_has_roots = rsp_has_ff;
   assign rsp_root_low  = rsp_low_ff;
   assign rsp_root_high = rsp_high_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

/* tb/quadratic_root_solver_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_checker
// Watches both channels of the root solver, predicts the roots of each
// accepted request and compares every response, field by field, in order.
// ----------------------------------------------------------------------------
module quadratic_root_solver_checker import qrs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  logic [W-1:0] req_coef_a,
   input  logic [W-1:0] req_coef_b,
   input  logic [W-1:0] req_coef_c,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  logic         rsp_has_roots,
   input  logic [W-1:0] rsp_root_low,
   input  logic [W-1:0] rsp_root_high,
   input  logic         rsp_saturated,
   output int           fail_count,
   output int           pending_count
);

   typedef struct packed {
      logic         has;
      logic [W-1:0] low;
      logic [W-1:0] high;
      logic         sat;
   } roots_type;

   roots_type pending_roots[$];

   function automatic logic [127:0] int_sqrt(input logic [127:0] n);
      logic [127:0] res;
      logic [127:0] b;
      res = '0;
      b   = 128'h1 << 126;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n   = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [W-1:0] rounded_quotient(input logic neg, input logic [127:0] num,
                                                     input logic [127:0] den,
                                                     inout logic sat);
      logic [127:0] q;
      logic [127:0] r;
      logic [127:0] lim;
      logic [W-1:0] mag;
      lim = neg ? (128'h1 << (W-1)) : ((128'h1 << (W-1)) - 1);
      if (den == 0) begin
         sat = 1'b1;
         mag = lim[W-1:0];
      end else begin
         q = num / den;
         r = num % den;
         if (r >= den - r) q = q + 1;
         if (q > lim) begin
            sat = 1'b1;
            mag = lim[W-1:0];
         end else begin
            mag = q[W-1:0];
         end
      end
      return neg ? (~mag + W'(1)) : mag;
   endfunction

   function automatic roots_type solve_roots(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic [W-1:0] c);
      roots_type    o;
      logic         an, bn, cn, qneg, sat;
      logic [127:0] am, bm, cm, p, rr, d, qm;
      logic [W-1:0] r1, r2, t;
      an = a[W-1];
      bn = b[W-1];
      cn = c[W-1];
      am = {96'h0, an ? (~a + W'(1)) : a};
      bm = {96'h0, bn ? (~b + W'(1)) : b};
      cm = {96'h0, cn ? (~c + W'(1)) : c};
      if (an && am == 0) am = 128'h1 << (W-1);
      if (bn && bm == 0) bm = 128'h1 << (W-1);
      if (cn && cm == 0) cm = 128'h1 << (W-1);
      p   = bm * bm;
      rr  = (am * cm) << 2;
      sat = 1'b0;
      o   = '0;
      if (an == cn && p < rr) return o;
      d    = (an != cn) ? p + rr : p - rr;
      qneg = !bn && bm != 0;
      if (d == 0) begin
         r1 = rounded_quotient(qneg != an, bm << FRAC_BITS, am << 1, sat);
         r2 = r1;
      end else begin
         qm = bm + int_sqrt(d);
         r1 = rounded_quotient(qneg != an, qm << FRAC_BITS, am << 1, sat);
         r2 = rounded_quotient(cn != qneg, cm << (FRAC_BITS + 1), qm, sat);
         if ($signed(r1) > $signed(r2)) begin
            t  = r1;
            r1 = r2;
            r2 = t;
         end
      end
      o.has  = 1'b1;
      o.low  = r1;
      o.high = r2;
      o.sat  = sat;
      return o;
   endfunction

   assign pending_count = pending_roots.size();

   always @(posedge clock) begin
      roots_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_roots.size() == 0) begin
               $display("%0t: unexpected response has=%0b low=%h high=%h sat=%0b", $time,
                        rsp_has_roots, rsp_root_low, rsp_root_high, rsp_saturated);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_roots.pop_front();
               if (want.has !== rsp_has_roots || want.low !== rsp_root_low ||
                   want.high !== rsp_root_high || want.sat !== rsp_saturated) begin
                  $display("%0t: expected has=%0b low=%h high=%h sat=%0b", $time,
                           want.has, want.low, want.high, want.sat);
                  $display("%0t:   actual has=%0b low=%h high=%h sat=%0b", $time,
                           rsp_has_roots, rsp_root_low, rsp_root_high, rsp_saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            pending_roots.push_back(solve_roots(req_coef_a, req_coef_b, req_coef_c));
      end
   end

endmodule

/* tb/quadratic_root_solver_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_core_tb
// Drives directed and random coefficient requests into the root solver with
// random gaps and back-pressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core_tb;
   import qrs_pkg::*;

   localparam int ONE = 1 << FRAC_BITS;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   logic [W-1:0] req_coef_a = '0;
   logic [W-1:0] req_coef_b = '0;
   logic [W-1:0] req_coef_c = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic         rsp_has_roots;
   logic [W-1:0] rsp_root_low;
   logic [W-1:0] rsp_root_high;
   logic         rsp_saturated;
   logic         quiet = 1'b0;
   int           fail_count;
   int           pending_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quadratic_root_solver_core i_dut (.*);

   quadratic_root_solver_checker i_checker (.*);

   always @(posedge clock)
      rsp_ready <= reset ? 1'b0 : (quiet || $urandom_range(99) >= 15);

   task automatic send_request(input logic [W-1:0] a, input logic [W-1:0] b,
                               input logic [W-1:0] c);
      while (!quiet && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [W-1:0] pick_coef();
      case ($urandom_range(9))
         0:       return W'($urandom);
         1:       return {1'($urandom_range(1)), {(W-1){$urandom_range(1) == 1}}};
         2:       return W'($signed($urandom_range(2 * ONE)) - ONE);
         3:       return '0;
         default: return W'($signed($urandom_range(16 * ONE)) - 8 * ONE);
      endcase
   endfunction

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [W-1:0] a, b, c;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, zero divisors, double root, no roots, overflow
      send_request('0, '0, '0);
      send_request(ONE, -3 * ONE, 2 * ONE);
      send_request(ONE, 2 * ONE, ONE);
      send_request(ONE, '0, ONE);
      send_request(ONE, '0, -4 * ONE);
      send_request('0, 2 * ONE, -ONE);
      send_request('0, '0, ONE);
      send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_request(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0001);
      send_request(32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
      send_request(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_request(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
      send_request(-ONE, '0, ONE);
      send_request(2 * ONE, -4 * ONE, 2 * ONE);
      send_request(ONE, ONE, '0);
      send_request(-ONE, 32'h8000_0000, '0);
      send_request(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
      send_request(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
      for (int i = 0; i < 1450; i++) begin
         quiet <= (i >= 600 && i < 800);
         a = pick_coef();
         c = pick_coef();
         b = pick_coef();
         if ($urandom_range(9) == 0) begin
            // perfect square: b = 2*k*sqrt-like pairing for double roots
            a = W'($signed($urandom_range(8 * ONE)) - 4 * ONE);
            b = W'($signed(a) * 2);
            c = a;
         end
         send_request(a, b, c);
      end
      req_valid <= 1'b0;
      quiet     <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
